FILE: hw/rtl/lap_pkg.sv
// shared types, widths and constants for the log arena append allocator
`timescale 1ns / 1ps

package lap_pkg;

    // fixed record sizes
    localparam int HEADER_BYTES = 38;
    localparam int ENTRY_BYTES  = 25;
    localparam int WORD_BYTES   = 4;

    // field widths
    localparam int BASE_W  = 48;
    localparam int SIZE_W  = 40;
    localparam int BB_W    = 17;
    localparam int EPB_W   = 16;
    localparam int OFF_W   = 40;
    localparam int LEN_W   = 20;
    localparam int IDX_W   = 32;
    localparam int CNT_W   = 32;
    localparam int PLAIN_W = 64;
    localparam int SZ_W    = 16;
    localparam int ADDR_W  = 48;
    localparam int EOFF_W  = 16;
    localparam int STAT_W  = 3;

    // datapath widths
    localparam int DIR_W   = IDX_W + 1 + BB_W;
    localparam int NEED_W  = SIZE_W + 2;
    localparam int CHK_W   = DIR_W + 2;
    localparam int EPROD_W = EPB_W + 8;

    // register port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_LOCATE = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_ZERO  = 3'd2,
        ST_RANGE = 3'd3,
        ST_WRAP  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_BASE = 2'd0,
        REG_SIZE = 2'd1,
        REG_BB   = 2'd2,
        REG_EPB  = 2'd3
    } reg_idx_t;

    localparam logic [BB_W-1:0]  BB_RESET  = 17'd8192;
    localparam logic [EPB_W-1:0] EPB_RESET = 16'd327;

    typedef struct packed {
        logic [BASE_W-1:0] region_base;
        logic [SIZE_W-1:0] region_size;
        logic [BB_W-1:0]   block_bytes;
        logic [EPB_W-1:0]  entries_per_block;
    } cfg_t;

endpackage

FILE: hw/rtl/log_arena_append_allocator.sv
// Log arena append allocator, top level.
// Manages an append-only region: item data grows from offset 0 upward and a
// directory of fixed-size entries grows down from the region end.
// Request channel (req_valid / req_stall): operation plus its operands;
// append, read check, write check or directory locate.
// Response channel (rsp_valid / rsp_stall): status, address, granted length,
// entry offset and the counters after the request.
// Each request runs from acceptance to response through one 32-step
// pass of the shared divider (entry number over entries per block), then a
// multiply, a sum and an evaluate state. req_stall stays high meanwhile; the
// next request is taken the cycle after the response is loaded.
// The response sits in an output register: a stalled response holds, and
// the block still accepts a new request, but will not finish it until the
// held response is taken.
// Configuration is written through the APB-style port, by the user only while
// idle (the block does not enforce this); registers sit at byte addresses 0, 8, 16 and 24.
// Reset clears all counters and the sealed flag and loads the register
// defaults (block size 8192, 327 entries per block).
`timescale 1ns / 1ps

module log_arena_append_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lap_pkg::PADDR_W-1:0]   paddr,
    input  logic [lap_pkg::PDATA_W-1:0]   pwdata,
    output logic [lap_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    operation,
    input  logic [lap_pkg::SZ_W-1:0]      stored_size,
    input  logic [lap_pkg::SZ_W-1:0]      plain_size,
    input  logic [lap_pkg::OFF_W-1:0]     offset,
    input  logic [lap_pkg::LEN_W-1:0]     length,
    input  logic [lap_pkg::IDX_W-1:0]     entry_index,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [lap_pkg::STAT_W-1:0]    status,
    output logic [lap_pkg::ADDR_W-1:0]    address,
    output logic [lap_pkg::LEN_W-1:0]     granted_length,
    output logic [lap_pkg::EOFF_W-1:0]    entry_offset,
    output logic [lap_pkg::SIZE_W-1:0]    used_bytes,
    output logic [lap_pkg::CNT_W-1:0]     item_count,
    output logic [lap_pkg::CNT_W-1:0]     compressed_count,
    output logic                          sealed
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SUM  = 5'b01000,
        S_EVAL = 5'b10000
    } seq_t;

    lap_pkg::cfg_t cfg;

    seq_t state_reg;
    seq_t state_next;

    // latched request
    lap_pkg::op_t                 op_reg;
    logic [lap_pkg::SZ_W-1:0]     stored_reg;
    logic [lap_pkg::SZ_W-1:0]     plain_reg;
    logic [lap_pkg::OFF_W-1:0]    off_reg;
    logic [lap_pkg::LEN_W-1:0]    len_reg;
    logic [lap_pkg::IDX_W-1:0]    idx_reg;
    logic [lap_pkg::NEED_W-1:0]   need_reg;
    logic [lap_pkg::SIZE_W-1:0]   used_new_reg;
    logic [lap_pkg::OFF_W:0]      end_reg;
    logic [lap_pkg::ADDR_W-1:0]   base_size_reg;

    // intermediate results
    logic [lap_pkg::DIR_W-1:0]    prod_reg;
    logic [lap_pkg::EOFF_W-1:0]   eoff_reg;
    logic [lap_pkg::CHK_W-1:0]    chk_reg;
    logic [lap_pkg::SIZE_W-1:0]   lim_reg;
    logic [lap_pkg::ADDR_W-1:0]   loc_addr_reg;

    // arena state
    logic [lap_pkg::SIZE_W-1:0]   used_total_reg;
    logic [lap_pkg::CNT_W-1:0]    item_total_reg;
    logic [lap_pkg::CNT_W-1:0]    compressed_total_reg;
    logic [lap_pkg::PLAIN_W-1:0]  plain_total_reg;
    logic                         sealed_reg;

    // response register
    logic                         rsp_valid_reg;
    lap_pkg::status_t             status_reg;
    logic [lap_pkg::ADDR_W-1:0]   address_reg;
    logic [lap_pkg::LEN_W-1:0]    granted_reg;
    logic [lap_pkg::EOFF_W-1:0]   eoff_out_reg;

    logic                         req_take;
    logic                         rsp_free;
    logic                         eval_go;
    logic [lap_pkg::IDX_W-1:0]    div_k;
    logic [lap_pkg::EPB_W-1:0]    div_d;
    logic [lap_pkg::IDX_W-1:0]    div_q;
    logic [lap_pkg::EPB_W-1:0]    div_r;
    logic                         div_done;
    logic [lap_pkg::EPROD_W-1:0]  eprod;
    logic [lap_pkg::DIR_W-1:0]    prod_next;

    lap_pkg::status_t             ev_status;
    logic [lap_pkg::ADDR_W-1:0]   ev_addr;
    logic [lap_pkg::LEN_W-1:0]    ev_granted;
    logic [lap_pkg::EOFF_W-1:0]   ev_eoff;
    logic                         ev_append_ok;
    logic                         ev_refuse;
    logic [lap_pkg::SIZE_W-1:0]   room;

    lap_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshakes
    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign eval_go   = (state_reg == S_EVAL) && rsp_free;

    // divider operands: entry count for the directory size, or the entry index
    always_comb
    begin
        case (lap_pkg::op_t'(operation))
            lap_pkg::OP_APPEND: div_k = item_total_reg + 1'b1;
            lap_pkg::OP_LOCATE: div_k = entry_index;
            default:            div_k = item_total_reg;
        endcase
    end

    assign div_d = (cfg.entries_per_block == '0) ? lap_pkg::EPB_W'(1) : cfg.entries_per_block;

    lap_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_take),
        .dividend  (div_k),
        .divisor   (div_d),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req_take) state_next = S_DIV;
            S_DIV:  if (div_done) state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_EVAL;
            S_EVAL: if (rsp_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request capture and precomputed sums
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            op_reg        <= lap_pkg::op_t'(operation);
            stored_reg    <= stored_size;
            plain_reg     <= plain_size;
            off_reg       <= offset;
            len_reg       <= length;
            idx_reg       <= entry_index;
            need_reg      <= lap_pkg::NEED_W'(used_total_reg)
                             + lap_pkg::NEED_W'(stored_size)
                             + lap_pkg::NEED_W'(lap_pkg::HEADER_BYTES
                                                + 2 * lap_pkg::WORD_BYTES);
            used_new_reg  <= used_total_reg + lap_pkg::SIZE_W'(stored_size)
                             + lap_pkg::SIZE_W'(lap_pkg::HEADER_BYTES);
            end_reg       <= {1'b0, offset} + (lap_pkg::OFF_W + 1)'(length);
            base_size_reg <= cfg.region_base + lap_pkg::ADDR_W'(cfg.region_size);
        end
    end

    // directory size product and entry byte offset
    assign prod_next = ({1'b0, div_q} + 1'b1) * lap_pkg::DIR_W'(cfg.block_bytes);
    assign eprod     = lap_pkg::EPROD_W'(div_r) * lap_pkg::EPROD_W'(lap_pkg::ENTRY_BYTES);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_next;
            eoff_reg <= eprod[lap_pkg::EOFF_W-1:0];
        end
    end

    // space check, data limit and block address
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SUM)
        begin
            chk_reg      <= lap_pkg::CHK_W'(need_reg) + lap_pkg::CHK_W'(prod_reg);
            lim_reg      <= (prod_reg > lap_pkg::DIR_W'(cfg.region_size))
                            ? '0 : cfg.region_size - prod_reg[lap_pkg::SIZE_W-1:0];
            loc_addr_reg <= base_size_reg - prod_reg[lap_pkg::ADDR_W-1:0];
        end
    end

    // result of the request
    assign ev_refuse    = sealed_reg || (chk_reg > lap_pkg::CHK_W'(cfg.region_size));
    assign ev_append_ok = (op_reg == lap_pkg::OP_APPEND) && !ev_refuse;
    assign room         = lim_reg - off_reg;

    always_comb
    begin
        ev_status  = lap_pkg::ST_OK;
        ev_addr    = '0;
        ev_granted = '0;
        ev_eoff    = '0;
        case (op_reg)
            lap_pkg::OP_APPEND:
            begin
                if (ev_refuse)
                begin
                    ev_status = lap_pkg::ST_FULL;
                end
                else
                begin
                    ev_addr = lap_pkg::ADDR_W'(used_total_reg);
                    if (item_total_reg == '1)
                    begin
                        ev_status = lap_pkg::ST_WRAP;
                    end
                end
            end
            lap_pkg::OP_READ, lap_pkg::OP_WRITE:
            begin
                if (len_reg == '0)
                begin
                    ev_status = lap_pkg::ST_ZERO;
                end
                else if (off_reg >= lim_reg)
                begin
                    ev_status = lap_pkg::ST_RANGE;
                end
                else if (end_reg > {1'b0, lim_reg})
                begin
                    // read clamps at the limit, write is refused
                    if (op_reg == lap_pkg::OP_READ)
                    begin
                        ev_granted = room[lap_pkg::LEN_W-1:0];
                    end
                    else
                    begin
                        ev_status = lap_pkg::ST_RANGE;
                    end
                end
                else
                begin
                    ev_granted = len_reg;
                end
            end
            lap_pkg::OP_LOCATE:
            begin
                if (idx_reg >= item_total_reg)
                begin
                    ev_status = lap_pkg::ST_RANGE;
                end
                else
                begin
                    ev_addr = loc_addr_reg;
                    ev_eoff = eoff_reg;
                end
            end
            default: ev_status = lap_pkg::ST_OK;
        endcase
    end

    // arena counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_total_reg       <= '0;
            item_total_reg       <= '0;
            compressed_total_reg <= '0;
            plain_total_reg      <= '0;
            sealed_reg           <= 1'b0;
        end
        else if (eval_go && (op_reg == lap_pkg::OP_APPEND))
        begin
            if (ev_append_ok)
            begin
                used_total_reg  <= used_new_reg;
                item_total_reg  <= item_total_reg + 1'b1;
                plain_total_reg <= plain_total_reg + lap_pkg::PLAIN_W'(plain_reg);
                if (stored_reg < plain_reg)
                begin
                    compressed_total_reg <= compressed_total_reg + 1'b1;
                end
            end
            else
            begin
                sealed_reg <= 1'b1;
            end
        end
    end

    // response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (eval_go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (eval_go)
        begin
            status_reg   <= ev_status;
            address_reg  <= ev_addr;
            granted_reg  <= ev_granted;
            eoff_out_reg <= ev_eoff;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign address          = address_reg;
    assign granted_length   = granted_reg;
    assign entry_offset     = eoff_out_reg;
    assign used_bytes       = used_total_reg;
    assign item_count       = item_total_reg;
    assign compressed_count = compressed_total_reg;
    assign sealed           = sealed_reg;

endmodule

FILE: hw/rtl/lap_regs.sv
// configuration register file behind the register port
`timescale 1ns / 1ps

module lap_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lap_pkg::PADDR_W-1:0]   paddr,
    input  logic [lap_pkg::PDATA_W-1:0]   pwdata,
    output logic [lap_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output lap_pkg::cfg_t                 cfg
);

    lap_pkg::cfg_t    cfg_reg;
    lap_pkg::reg_idx_t idx;
    logic             wr_en;

    // 8-byte register slots
    assign idx    = lap_pkg::reg_idx_t'(paddr[4:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_base       <= '0;
            cfg_reg.region_size       <= '0;
            cfg_reg.block_bytes       <= lap_pkg::BB_RESET;
            cfg_reg.entries_per_block <= lap_pkg::EPB_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                lap_pkg::REG_BASE: cfg_reg.region_base <= pwdata[lap_pkg::BASE_W-1:0];
                lap_pkg::REG_SIZE: cfg_reg.region_size <= pwdata[lap_pkg::SIZE_W-1:0];
                lap_pkg::REG_BB:   cfg_reg.block_bytes <= pwdata[lap_pkg::BB_W-1:0];
                lap_pkg::REG_EPB:
                    cfg_reg.entries_per_block <= pwdata[lap_pkg::EPB_W-1:0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb
    begin
        case (idx)
            lap_pkg::REG_BASE: prdata = lap_pkg::PDATA_W'(cfg_reg.region_base);
            lap_pkg::REG_SIZE: prdata = lap_pkg::PDATA_W'(cfg_reg.region_size);
            lap_pkg::REG_BB:   prdata = lap_pkg::PDATA_W'(cfg_reg.block_bytes);
            lap_pkg::REG_EPB:  prdata = lap_pkg::PDATA_W'(cfg_reg.entries_per_block);
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/lap_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lap_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lap_pkg::IDX_W-1:0]   dividend,
    input  logic [lap_pkg::EPB_W-1:0]   divisor,
    output logic [lap_pkg::IDX_W-1:0]   quotient,
    output logic [lap_pkg::EPB_W-1:0]   remainder,
    output logic                        done
);

    localparam int CNT_BITS = $clog2(lap_pkg::IDX_W + 1);

    logic [lap_pkg::IDX_W-1:0] quo_reg;
    logic [lap_pkg::EPB_W-1:0] rem_reg;
    logic [lap_pkg::EPB_W-1:0] dsr_reg;
    logic [CNT_BITS-1:0]       cnt_reg;
    logic                      running_reg;
    logic                      done_reg;
    logic [lap_pkg::EPB_W:0]   trial;
    logic [lap_pkg::EPB_W:0]   diff;
    logic                      fits;

    // one trial subtraction
    assign trial = {rem_reg, quo_reg[lap_pkg::IDX_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= CNT_BITS'(lap_pkg::IDX_W);
            end
            else if (running_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (running_reg)
        begin
            quo_reg <= {quo_reg[lap_pkg::IDX_W-2:0], fits};
            rem_reg <= fits ? diff[lap_pkg::EPB_W-1:0] : trial[lap_pkg::EPB_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/lap_checker.sv
// port-level checks for the log arena append allocator
`timescale 1ns / 1ps

module lap_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [lap_pkg::STAT_W-1:0]    status,
    input  logic [lap_pkg::ADDR_W-1:0]    address,
    input  logic [lap_pkg::CNT_W-1:0]     item_count,
    input  logic                          sealed
);

    // a stalled response holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(address) && $stable(status))
    else $error("stalled response changed");

    // one request at a time: busy right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("second request taken while busy");

    // a refused append leaves the region sealed
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == lap_pkg::ST_FULL) |-> sealed)
    else $error("refusal without seal");

    // once sealed the region stays sealed
    assert property (@(posedge clk) disable iff (!rst_n)
        sealed |=> sealed)
    else $error("seal cleared");

    // a count wrap shows a zero item count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == lap_pkg::ST_WRAP) |-> (item_count == '0))
    else $error("wrap status with nonzero count");

endmodule

bind log_arena_append_allocator lap_checker u_lap_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .address    (address),
    .item_count (item_count),
    .sealed     (sealed)
);

FILE: bench/arena_reply_checker.sv
// reply predictor and checker for the log arena append allocator bench
`timescale 1ns / 1ps

module arena_reply_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    // register port, watched
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [lap_pkg::PADDR_W-1:0]   paddr,
    input  logic [lap_pkg::PDATA_W-1:0]   pwdata,
    // request channel, watched
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [1:0]                    operation,
    input  logic [lap_pkg::SZ_W-1:0]      stored_size,
    input  logic [lap_pkg::SZ_W-1:0]      plain_size,
    input  logic [lap_pkg::OFF_W-1:0]     offset,
    input  logic [lap_pkg::LEN_W-1:0]     length,
    input  logic [lap_pkg::IDX_W-1:0]     entry_index,
    // response channel, watched
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [lap_pkg::STAT_W-1:0]    status,
    input  logic [lap_pkg::ADDR_W-1:0]    address,
    input  logic [lap_pkg::LEN_W-1:0]     granted_length,
    input  logic [lap_pkg::EOFF_W-1:0]    entry_offset,
    input  logic [lap_pkg::SIZE_W-1:0]    used_bytes,
    input  logic [lap_pkg::CNT_W-1:0]     item_count,
    input  logic [lap_pkg::CNT_W-1:0]     compressed_count,
    input  logic                          sealed,
    // to the bench top
    output int                            mismatches,
    output int                            outstanding,
    output logic [lap_pkg::SIZE_W-1:0]    used_now,
    output logic [lap_pkg::CNT_W-1:0]     items_now
);

    import lap_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   address;
        logic [LEN_W-1:0]    granted;
        logic [EOFF_W-1:0]   eoff;
        logic [SIZE_W-1:0]   used;
        logic [CNT_W-1:0]    items;
        logic [CNT_W-1:0]    compressed;
        logic                sealed;
    } reply_t;

    // mirrored registers and allocator state
    cfg_t                cfg;
    logic [SIZE_W-1:0]   used_q;
    logic [CNT_W-1:0]    item_q;
    logic [CNT_W-1:0]    comp_q;
    logic                sealed_q;

    reply_t              replies_due[$];
    reply_t              want;
    reply_t              seen;
    int                  reply_no;

    // directory footprint for k entries
    function automatic logic [63:0] dir_span(logic [31:0] k);
        logic [63:0] per;
        per = (cfg.entries_per_block == '0) ? 64'd1 : 64'(cfg.entries_per_block);
        return (64'(k) / per + 64'd1) * 64'(cfg.block_bytes);
    endfunction

    // apply one request to the mirrored state and form its reply
    function automatic reply_t arena_outcome(op_t op, logic [SZ_W-1:0] st,
                                             logic [SZ_W-1:0] pl,
                                             logic [OFF_W-1:0] off,
                                             logic [LEN_W-1:0] len,
                                             logic [IDX_W-1:0] idx);
        reply_t      r;
        logic [63:0] need;
        logic [63:0] dir;
        logic [63:0] lim;
        logic [63:0] per;
        logic [63:0] blk;
        r = '0;
        case (op)
            OP_APPEND:
            begin
                need = 64'(st) + HEADER_BYTES + WORD_BYTES;
                if (sealed_q || 64'(used_q) + need + WORD_BYTES + dir_span(item_q + 32'd1)
                        > 64'(cfg.region_size))
                begin
                    sealed_q = 1'b1;
                    r.status = ST_FULL;
                end
                else
                begin
                    r.address = ADDR_W'(used_q);
                    used_q = used_q + SIZE_W'(st) + SIZE_W'(HEADER_BYTES);
                    if (st < pl)
                        comp_q = comp_q + 32'd1;
                    item_q = item_q + 32'd1;
                    if (item_q == '0)
                        r.status = ST_WRAP;
                end
            end
            OP_READ, OP_WRITE:
            begin
                dir = dir_span(item_q);
                lim = (dir > 64'(cfg.region_size)) ? 64'd0 : 64'(cfg.region_size) - dir;
                if (len == '0)
                    r.status = ST_ZERO;
                else if (64'(off) >= lim)
                    r.status = ST_RANGE;
                else if (op == OP_READ)
                    r.granted = (64'(off) + 64'(len) > lim) ? LEN_W'(lim - 64'(off)) : len;
                else if (64'(off) + 64'(len) > lim)
                    r.status = ST_RANGE;
                else
                    r.granted = len;
            end
            default:
            begin
                if (idx >= item_q)
                    r.status = ST_RANGE;
                else
                begin
                    per = (cfg.entries_per_block == '0) ? 64'd1
                                                        : 64'(cfg.entries_per_block);
                    blk = 64'(idx) / per;
                    r.eoff = EOFF_W'((64'(idx) - blk * per) * ENTRY_BYTES);
                    r.address = ADDR_W'(64'(cfg.region_base) + 64'(cfg.region_size)
                                        - (blk + 64'd1) * 64'(cfg.block_bytes));
                end
            end
        endcase
        r.used = used_q;
        r.items = item_q;
        r.compressed = comp_q;
        r.sealed = sealed_q;
        return r;
    endfunction

    // watch register writes, requests and responses
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.region_base = '0;
            cfg.region_size = '0;
            cfg.block_bytes = BB_RESET;
            cfg.entries_per_block = EPB_RESET;
            used_q = '0;
            item_q = '0;
            comp_q = '0;
            sealed_q = 1'b0;
            replies_due.delete();
            reply_no = 0;
            mismatches = 0;
        end
        else
        begin
            // register write completes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:3]))
                    REG_BASE: cfg.region_base = pwdata[BASE_W-1:0];
                    REG_SIZE: cfg.region_size = pwdata[SIZE_W-1:0];
                    REG_BB:   cfg.block_bytes = pwdata[BB_W-1:0];
                    REG_EPB:  cfg.entries_per_block = pwdata[EPB_W-1:0];
                    default:  ;
                endcase
            end

            // accepted request
            if (req_valid && !req_stall)
                replies_due.push_back(arena_outcome(op_t'(operation), stored_size,
                                                    plain_size, offset, length,
                                                    entry_index));

            // accepted response
            if (rsp_valid && !rsp_stall)
            begin
                seen.status = status_t'(status);
                seen.address = address;
                seen.granted = granted_length;
                seen.eoff = entry_offset;
                seen.used = used_bytes;
                seen.items = item_count;
                seen.compressed = compressed_count;
                seen.sealed = sealed;
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply %0d arrived with no request outstanding", reply_no);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("reply %0d mismatch", reply_no);
                            $display("  want st=%0d addr=%h gl=%h eo=%h used=%h n=%h c=%h s=%b",
                                     want.status, want.address, want.granted, want.eoff,
                                     want.used, want.items, want.compressed, want.sealed);
                            $display("  got  st=%0d addr=%h gl=%h eo=%h used=%h n=%h c=%h s=%b",
                                     seen.status, seen.address, seen.granted, seen.eoff,
                                     seen.used, seen.items, seen.compressed, seen.sealed);
                        end
                    end
                end
                reply_no++;
            end
        end
        outstanding = replies_due.size();
        used_now = used_q;
        items_now = item_q;
    end

endmodule

FILE: bench/log_arena_append_allocator_tb.sv
// bench top for the log arena append allocator: stimulus, flow control and verdict
`timescale 1ns / 1ps

module log_arena_append_allocator_tb;

    import lap_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  req_valid;
    logic                  req_stall;
    logic [1:0]            operation;
    logic [SZ_W-1:0]       stored_size;
    logic [SZ_W-1:0]       plain_size;
    logic [OFF_W-1:0]      offset;
    logic [LEN_W-1:0]      length;
    logic [IDX_W-1:0]      entry_index;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [STAT_W-1:0]     status;
    logic [ADDR_W-1:0]     address;
    logic [LEN_W-1:0]      granted_length;
    logic [EOFF_W-1:0]     entry_offset;
    logic [SIZE_W-1:0]     used_bytes;
    logic [CNT_W-1:0]      item_count;
    logic [CNT_W-1:0]      compressed_count;
    logic                  sealed;

    int                    mismatches;
    int                    outstanding;
    logic [SIZE_W-1:0]     used_now;
    logic [CNT_W-1:0]      items_now;

    // register values last written, for aiming offsets and sizes
    logic [SIZE_W-1:0]     cur_size;
    logic [BB_W-1:0]       cur_bb;
    logic [EPB_W-1:0]      cur_epb;

    bit                    calm;
    bit                    long_hold;

    log_arena_append_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_stall(req_stall), .operation(operation),
        .stored_size(stored_size), .plain_size(plain_size), .offset(offset),
        .length(length), .entry_index(entry_index),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status),
        .address(address), .granted_length(granted_length),
        .entry_offset(entry_offset), .used_bytes(used_bytes),
        .item_count(item_count), .compressed_count(compressed_count), .sealed(sealed)
    );

    arena_reply_checker u_reply_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .req_valid(req_valid), .req_stall(req_stall), .operation(operation),
        .stored_size(stored_size), .plain_size(plain_size), .offset(offset),
        .length(length), .entry_index(entry_index),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status),
        .address(address), .granted_length(granted_length),
        .entry_offset(entry_offset), .used_bytes(used_bytes),
        .item_count(item_count), .compressed_count(compressed_count), .sealed(sealed),
        .mismatches(mismatches), .outstanding(outstanding),
        .used_now(used_now), .items_now(items_now)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // directory footprint for k entries under the current registers
    function automatic logic [63:0] dir_span(logic [31:0] k);
        logic [63:0] per;
        per = (cur_epb == '0) ? 64'd1 : 64'(cur_epb);
        return (64'(k) / per + 64'd1) * 64'(cur_bb);
    endfunction

    // current end of the data area
    function automatic logic [63:0] room();
        logic [63:0] d;
        d = dir_span(items_now);
        return (d > 64'(cur_size)) ? 64'd0 : 64'(cur_size) - d;
    endfunction

    // one register write: setup, access, then back to idle
    task automatic put_reg(reg_idx_t idx, logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SIZE: cur_size = val[SIZE_W-1:0];
            REG_BB:   cur_bb = val[BB_W-1:0];
            REG_EPB:  cur_epb = val[EPB_W-1:0];
            default:  ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_arena(logic [47:0] base, logic [39:0] size, logic [16:0] bb,
                             logic [15:0] epb);
        put_reg(REG_BB, 64'(bb));
        put_reg(REG_EPB, 64'(epb));
        put_reg(REG_BASE, 64'(base));
        put_reg(REG_SIZE, 64'(size));
    endtask

    // offer one request and hold it until taken
    task automatic issue(op_t op, logic [15:0] st, logic [15:0] pl, logic [39:0] off,
                         logic [19:0] len, logic [31:0] idx);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        stored_size <= st;
        plain_size <= pl;
        offset <= off;
        length <= len;
        entry_index <= idx;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    // random request, offsets and indexes aimed near the live limits
    task automatic random_request(bit with_appends);
        int          r;
        op_t         op;
        logic [15:0] st;
        logic [15:0] pl;
        logic [39:0] off;
        logic [19:0] len;
        logic [31:0] idx;
        logic [63:0] lim;
        logic [63:0] back;
        st = 16'($urandom);
        pl = 16'($urandom);
        off = 40'({$urandom, $urandom});
        len = 20'($urandom);
        idx = $urandom;
        r = $urandom_range(0, 99);
        if (r < 35 && with_appends)
            op = OP_APPEND;
        else if (r < 55)
            op = OP_READ;
        else if (r < 75)
            op = OP_WRITE;
        else
            op = OP_LOCATE;
        case (op)
            OP_APPEND:
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    st = '0;
                else if (r == 1)
                    st = '1;
                else if (r < 4)
                    pl = st;
            end
            OP_READ, OP_WRITE:
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    len = '0;
                else if (r < 14)
                    len = '1;
                else if (r < 55)
                    len = 20'($urandom_range(1, 64));
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    lim = room();
                    back = 64'($urandom_range(0, int'(len) + 16));
                    off = (lim + 64'd8 >= back) ? 40'(lim + 64'd8 - back) : '0;
                end
                else if (r < 75)
                    off = 40'($urandom_range(0, 4096));
            end
            default:
            begin
                r = $urandom_range(0, 99);
                if (r < 60 && items_now != '0)
                    idx = $urandom_range(0, items_now - 32'd1);
                else if (r < 75)
                    idx = items_now;
                else if (r < 85)
                    idx = items_now + 32'($urandom_range(1, 4));
            end
        endcase
        issue(op, st, pl, off, len, idx);
    endtask

    // random stretch, with calm runs of back-to-back traffic
    task automatic run_random(int n, bit with_appends);
        for (int i = 0; i < n; i++)
        begin
            calm = ((i % 200) < 30);
            random_request(with_appends);
        end
        calm = 1'b0;
    endtask

    // let every reply come back and the block go quiet
    task automatic drain();
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // response side stalls, including one long hold-off
    initial
    begin : response_side
        int hold;
        bit long_done;
        long_done = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold && !long_done)
            begin
                long_done = 1'b1;
                hold = LONG_HOLD;
            end
            else
                hold = idle_gap();
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // stimulus and verdict
    initial
    begin : stimulus
        logic [63:0] lim;
        logic [15:0] st;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_valid = 1'b0;
        operation = OP_APPEND;
        stored_size = '0;
        plain_size = '0;
        offset = '0;
        length = '0;
        entry_index = '0;
        cur_size = '0;
        cur_bb = BB_RESET;
        cur_epb = EPB_RESET;
        calm = 1'b0;
        long_hold = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // base, size and entries per block at their top values, address arithmetic wraps
        set_arena(48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 17'd65536, 16'd65535);
        issue(OP_LOCATE, '0, '0, '0, 20'd1, '0);
        issue(OP_READ, '0, '0, '0, '0, '0);
        issue(OP_WRITE, '0, '0, '0, '0, '0);
        issue(OP_APPEND, 16'd0, 16'd0, '0, '0, '0);
        issue(OP_APPEND, 16'hFFFF, 16'hFFFF, '0, '0, '0);
        issue(OP_APPEND, 16'd100, 16'd2000, '0, '0, '0);
        issue(OP_APPEND, 16'd5000, 16'd10, '0, '0, '0);
        issue(OP_APPEND, 16'hAAAA, 16'h5555, '0, '0, '0);
        issue(OP_APPEND, 16'h5555, 16'hAAAA, '0, '0, '0);
        lim = room();
        issue(OP_READ, '0, '0, '0, 20'hFFFFF, '0);
        issue(OP_READ, '0, '0, 40'(lim - 64'd1), 20'hFFFFF, '0);
        issue(OP_READ, '0, '0, 40'(lim), 20'd1, '0);
        issue(OP_READ, '0, '0, 40'hFF_FFFF_FFFF, 20'd1, '0);
        issue(OP_WRITE, '0, '0, 40'(lim - 64'd10), 20'd10, '0);
        issue(OP_WRITE, '0, '0, 40'(lim - 64'd10), 20'd11, '0);
        issue(OP_WRITE, '0, '0, 40'(lim - 64'd1), 20'hFFFFF, '0);
        issue(OP_LOCATE, '0, '0, '0, '0, 32'd0);
        issue(OP_LOCATE, '0, '0, '0, '0, items_now - 32'd1);
        issue(OP_LOCATE, '0, '0, '0, '0, items_now);
        issue(OP_LOCATE, '0, '0, '0, '0, 32'hFFFF_FFFF);
        issue(OP_READ, '0, '0, 40'h55_5555_5555, 20'hAAAAA, '0);
        issue(OP_WRITE, '0, '0, 40'hAA_AAAA_AAAA, 20'h55555, '0);
        run_random(380, 1'b1);
        drain();

        // smallest blocks, one entry each, with a long response hold-off
        set_arena('0, 40'({$urandom, $urandom}) | (40'd1 << 39), 17'd512, 16'd1);
        long_hold = 1'b1;
        run_random(400, 1'b1);
        drain();

        // zero entries per block counts as one
        set_arena(48'({$urandom, $urandom}), 40'({$urandom, $urandom}) | (40'd1 << 39),
                  17'($urandom_range(512, 65536)), 16'd0);
        run_random(350, 1'b1);
        drain();

        // empty region: directory outgrows it, no appends here
        set_arena(48'($urandom_range(0, 65535)), 40'd0, 17'($urandom_range(512, 65536)),
                  16'($urandom_range(1, 65535)));
        run_random(300, 1'b0);
        drain();

        // region sized so the next append lands exactly on the directory
        st = 16'($urandom);
        put_reg(REG_BB, 64'd512);
        put_reg(REG_EPB, 64'($urandom_range(1, 8)));
        put_reg(REG_BASE, 64'({$urandom, $urandom}));
        put_reg(REG_SIZE, 64'(used_now) + 64'(st) + HEADER_BYTES + 2 * WORD_BYTES
                          + dir_span(items_now + 32'd1));
        issue(OP_APPEND, st, 16'($urandom), '0, '0, '0);
        issue(OP_APPEND, 16'd0, 16'd1, '0, '0, '0);
        issue(OP_APPEND, 16'($urandom), 16'($urandom), '0, '0, '0);
        run_random(480, 1'b1);
        drain();

        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
